[sv/dense_prim_mst_top_defines.svh]
// Assertion macros shared by the spanning tree block.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef DENSE_PRIM_MST_TOP_DEFINES_SVH
`define DENSE_PRIM_MST_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising edge outside reset
`define DPM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dense_prim_mst: assertion failed");

// Next-cycle implication, sampled on the rising edge outside reset
`define DPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dense_prim_mst: assertion failed");

`else

`define DPM_ASSERT_IMPL(lbl, ante, cons)
`define DPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[sv/dpm_pkg.sv]
package dpm_pkg;

    // Defaults for the top level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    // Fixed field widths of the ports
    localparam int VTX_FIELD_W = 6;
    localparam int WGT_FIELD_W = 16;
    localparam int CFG_VC_W    = 7;
    localparam int CFG_SRC_W   = 6;
    localparam int CFG_DATA_W  = 7;

    // Configuration register indexes
    typedef enum logic {
        CFG_VERTEX_COUNT  = 1'b0,
        CFG_SOURCE_VERTEX = 1'b1
    } cfg_idx_t;

    // One matrix entry request
    typedef struct packed {
        logic [VTX_FIELD_W-1:0] row_index;
        logic [VTX_FIELD_W-1:0] column_index;
        logic [WGT_FIELD_W-1:0] edge_weight;
        logic                   load_last;
    } item_t;

    // One tree edge report
    typedef struct packed {
        logic [VTX_FIELD_W-1:0] tree_vertex;
        logic [VTX_FIELD_W-1:0] parent_vertex;
        logic [WGT_FIELD_W-1:0] tree_edge_weight;
        logic                   reachable;
        logic                   result_last;
    } result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_OUT_ADDR,
        ST_OUT_PAR,
        ST_OUT_WT
    } state_t;

    // Control from the sequencer to the key unit
    typedef struct packed {
        logic issue;
        logic first_round;
        logic clear_best;
    } kctl_t;

    // Status from the key unit
    typedef struct packed {
        logic busy;
        logic none_found;
    } kst_t;

endpackage

[sv/dpm_key_unit.sv]
`include "dense_prim_mst_top_defines.svh"

// Key and parent store with the relax pipeline and the nearest-vertex search.
// Stage 0 issues the read, stage 1 relaxes and writes back, stage 2 updates
// the running minimum over vertices outside the tree.
module dpm_key_unit #(
    parameter int MAX_VERTICES = dpm_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dpm_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dpm_pkg::kctl_t                    ctrl,
    input  logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0]   pick_u,
    input  logic [MAX_VERTICES-1:0]           in_tree,
    input  logic [WEIGHT_BITS-1:0]            wgt_rd,
    output dpm_pkg::kst_t                     stat,
    output logic [$clog2(MAX_VERTICES)-1:0]   best_v,
    output logic [$clog2(MAX_VERTICES)-1:0]   parent_rd
);
    import dpm_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int KW = WEIGHT_BITS + 1;
    localparam int EW = KW + VW;
    localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    logic [EW-1:0] kmem [MAX_VERTICES];
    logic [EW-1:0] kmem_rd_reg;

    logic          s1_valid_reg;
    logic [VW-1:0] s1_v_reg;
    logic          s2_valid_reg;
    logic [VW-1:0] s2_v_reg;
    logic [KW-1:0] s2_key_reg;
    logic          s2_cand_reg;

    logic [KW-1:0] best_key_reg;
    logic [VW-1:0] best_v_reg;

    logic [KW-1:0] old_key;
    logic [VW-1:0] old_par;
    logic [KW-1:0] wgt_key;
    logic          outside;
    logic          relax;
    logic [KW-1:0] new_key;
    logic [VW-1:0] new_par;

    // Store: one read and one write port, read data registered
    always_ff @(posedge clk)
    begin
        kmem_rd_reg <= kmem[rd_addr];
        if (s1_valid_reg)
        begin
            kmem[s1_v_reg] <= {new_key, new_par};
        end
    end

    // Stage 1: relax against the picked vertex's row
    always_comb
    begin
        old_key = ctrl.first_round ? KEY_INF : kmem_rd_reg[EW-1:VW];
        old_par = kmem_rd_reg[VW-1:0];
        wgt_key = {1'b0, wgt_rd};
        outside = !in_tree[s1_v_reg];
        relax   = outside && (wgt_rd != '0) && (wgt_key < old_key);
        new_key = relax ? wgt_key : old_key;
        new_par = relax ? pick_u : old_par;
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_v_reg    <= rd_addr;
        s2_v_reg    <= s1_v_reg;
        s2_key_reg  <= new_key;
        s2_cand_reg <= outside;
    end

    // Stage 2: running minimum, lowest index wins ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_key_reg <= KEY_INF;
            best_v_reg   <= '0;
        end
        else if (ctrl.clear_best)
        begin
            best_key_reg <= KEY_INF;
        end
        else if (s2_valid_reg && s2_cand_reg && (s2_key_reg < best_key_reg))
        begin
            best_key_reg <= s2_key_reg;
            best_v_reg   <= s2_v_reg;
        end
    end

    assign stat.busy       = s1_valid_reg | s2_valid_reg;
    assign stat.none_found = best_key_reg[KW-1];
    assign best_v          = best_v_reg;
    assign parent_rd       = kmem_rd_reg[VW-1:0];

    // A key is either finite or exactly the infinite mark
    `DPM_ASSERT_IMPL(a_best_range, best_key_reg[KW-1], best_key_reg[KW-2:0] == '0)
    // A finite best always names a vertex still outside the tree
    `DPM_ASSERT_IMPL(a_best_outside, !best_key_reg[KW-1], !in_tree[best_v_reg])
    // Clearing the minimum mid-sweep would lose a candidate
    `DPM_ASSERT_IMPL(a_clear_idle, ctrl.clear_best, !s1_valid_reg && !s2_valid_reg)

endmodule

[sv/dense_prim_mst_top.sv]
// Load: one matrix entry request per cycle, stall low while loading.
// Tree growth: up to n rounds, n = vertices in use; each round streams one matrix row
// and the key store through a three-stage pipeline.
// Output: address, parent and weight states per reported vertex, the source is not reported;
// the result register lets the next load start while the final report waits.
// Reset clears control and sets vertex_count to MAX_VERTICES, source_vertex 0; memories are not cleared.
`include "dense_prim_mst_top_defines.svh"

module dense_prim_mst_top #(
    parameter int MAX_VERTICES = dpm_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dpm_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  dpm_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output dpm_pkg::result_t                  result,
    input  logic                              cfg_wr_en,
    input  dpm_pkg::cfg_idx_t                 cfg_index,
    input  logic [dpm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dpm_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam logic [CFG_VC_W-1:0] VC_MAX = CFG_VC_W'(MAX_VERTICES);

    state_t state_reg, state_next;

    logic [CFG_VC_W-1:0]  vcount_reg;
    logic [CFG_SRC_W-1:0] source_reg;

    logic [WEIGHT_BITS-1:0] wmem [MAX_VERTICES * MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] wmem_rd_reg;
    logic [AW-1:0]          wmem_waddr;
    logic [AW-1:0]          wmem_raddr;
    logic                   wmem_we;

    logic [MAX_VERTICES-1:0] in_tree_reg;
    logic [VW-1:0] pick_u_reg;
    logic [VW-1:0] src_reg;
    logic [VW-1:0] last_idx_reg;
    logic [VW-1:0] last_out_reg;
    logic [VW-1:0] scan_v_reg;
    logic [VW-1:0] out_v_reg;
    logic [VW-1:0] par_reg;
    logic          first_round_reg;

    logic          result_valid_reg;
    result_t       result_reg;

    logic          item_acc;
    logic          start_run;
    logic          next_round;
    logic          load_out;
    logic          out_adv;
    logic          out_last;
    kctl_t         kctl;
    kst_t          kst;
    logic [VW-1:0] k_rd_addr;
    logic [VW-1:0] best_v;
    logic [VW-1:0] k_parent;
    logic [VW-1:0] rd_par;

    logic [CFG_VC_W-1:0] last_full;
    logic [VW-1:0]       last_idx_eff;
    logic [VW-1:0]       src_eff;
    logic [VW-1:0]       last_out_eff;

    assign item_stall = (state_reg != ST_LOAD);
    assign item_acc   = item_valid && !item_stall;
    assign out_last   = (out_v_reg == last_idx_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VC_MAX;
            source_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT:  vcount_reg <= cfg_data[CFG_VC_W-1:0];
                CFG_SOURCE_VERTEX: source_reg <= cfg_data[CFG_SRC_W-1:0];
                default:           ;
            endcase
        end
    end

    // Run limits: clamp the vertex count, fall back to vertex 0 for a bad source
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            last_full = '0;
        end
        else if (vcount_reg > VC_MAX)
        begin
            last_full = VC_MAX - CFG_VC_W'(1);
        end
        else
        begin
            last_full = vcount_reg - CFG_VC_W'(1);
        end
        last_idx_eff = last_full[VW-1:0];
        src_eff      = ({1'b0, source_reg} <= last_full) ? source_reg[VW-1:0] : '0;
        last_out_eff = (src_eff == last_idx_eff) ? (last_idx_eff - VW'(1)) : last_idx_eff;
    end

    // Matrix store: entries outside the matrix are dropped
    always_comb
    begin
        wmem_we    = item_acc
                     && ({1'b0, item.row_index} < VC_MAX)
                     && ({1'b0, item.column_index} < VC_MAX);
        wmem_waddr = AW'(int'(item.row_index[VW-1:0]) * MAX_VERTICES
                         + int'(item.column_index[VW-1:0]));
        rd_par     = (state_reg == ST_OUT_PAR) ? k_parent : par_reg;
        if (state_reg == ST_SWEEP)
        begin
            wmem_raddr = AW'(int'(pick_u_reg) * MAX_VERTICES + int'(scan_v_reg));
        end
        else
        begin
            wmem_raddr = AW'(int'(out_v_reg) * MAX_VERTICES + int'(rd_par));
        end
    end

    always_ff @(posedge clk)
    begin
        wmem_rd_reg <= wmem[wmem_raddr];
        if (wmem_we)
        begin
            wmem[wmem_waddr] <= WEIGHT_BITS'(item.edge_weight);
        end
    end

    // Key store, relax pipeline and nearest-vertex search
    assign k_rd_addr = (state_reg == ST_SWEEP) ? scan_v_reg : out_v_reg;

    dpm_key_unit #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (kctl),
        .rd_addr   (k_rd_addr),
        .pick_u    (pick_u_reg),
        .in_tree   (in_tree_reg),
        .wgt_rd    (wmem_rd_reg),
        .stat      (kst),
        .best_v    (best_v),
        .parent_rd (k_parent)
    );

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and controls
    always_comb
    begin
        state_next       = state_reg;
        kctl.issue       = 1'b0;
        kctl.first_round = first_round_reg;
        kctl.clear_best  = 1'b0;
        start_run        = 1'b0;
        next_round       = 1'b0;
        load_out         = 1'b0;
        out_adv          = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_acc && item.load_last)
                begin
                    start_run       = 1'b1;
                    kctl.clear_best = 1'b1;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                kctl.issue = 1'b1;
                if (scan_v_reg == last_idx_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last relax and compare to land
                if (!kst.busy)
                begin
                    if (kst.none_found)
                    begin
                        state_next = ST_OUT_ADDR;
                    end
                    else
                    begin
                        next_round      = 1'b1;
                        kctl.clear_best = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                end
            end
            ST_OUT_ADDR:
            begin
                if (out_v_reg == src_reg)
                begin
                    out_adv    = 1'b1;
                    state_next = out_last ? ST_LOAD : ST_OUT_ADDR;
                end
                else
                begin
                    state_next = ST_OUT_PAR;
                end
            end
            ST_OUT_PAR:
            begin
                state_next = ST_OUT_WT;
            end
            ST_OUT_WT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    out_adv    = 1'b1;
                    state_next = out_last ? ST_LOAD : ST_OUT_ADDR;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Tree membership and round bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg     <= '0;
            first_round_reg <= 1'b0;
            scan_v_reg      <= '0;
            out_v_reg       <= '0;
            pick_u_reg      <= '0;
            src_reg         <= '0;
            last_idx_reg    <= '0;
            last_out_reg    <= '0;
        end
        else if (start_run)
        begin
            in_tree_reg     <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << src_eff;
            first_round_reg <= 1'b1;
            scan_v_reg      <= '0;
            out_v_reg       <= '0;
            pick_u_reg      <= src_eff;
            src_reg         <= src_eff;
            last_idx_reg    <= last_idx_eff;
            last_out_reg    <= last_out_eff;
        end
        else if (next_round)
        begin
            in_tree_reg[best_v] <= 1'b1;
            first_round_reg     <= 1'b0;
            scan_v_reg          <= '0;
            pick_u_reg          <= best_v;
        end
        else
        begin
            if (state_reg == ST_SWEEP)
            begin
                scan_v_reg <= scan_v_reg + VW'(1);
            end
            if (out_adv)
            begin
                out_v_reg <= out_v_reg + VW'(1);
            end
        end
    end

    // Parent of the vertex being reported
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT_PAR)
        begin
            par_reg <= k_parent;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg.tree_vertex      <= VTX_FIELD_W'(out_v_reg);
            result_reg.reachable        <= in_tree_reg[out_v_reg];
            result_reg.result_last      <= (out_v_reg == last_out_reg);
            if (in_tree_reg[out_v_reg])
            begin
                result_reg.parent_vertex    <= VTX_FIELD_W'(par_reg);
                result_reg.tree_edge_weight <= WGT_FIELD_W'(wmem_rd_reg);
            end
            else
            begin
                result_reg.parent_vertex    <= '0;
                result_reg.tree_edge_weight <= '0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The root stays in the tree through every sweep
    `DPM_ASSERT_IMPL(a_src_in_tree, state_reg == ST_SWEEP, in_tree_reg[src_reg])
    // A vertex is picked only once per run
    `DPM_ASSERT_IMPL(a_pick_fresh, next_round, !in_tree_reg[best_v])
    // Reports are produced only by the output phase
    `DPM_ASSERT_IMPL(a_out_source, $rose(result_valid_reg), $past(state_reg == ST_OUT_WT))
    // Starting a new round leaves the search cleared
    `DPM_ASSERT_NEXT(a_round_clears, next_round, kst.none_found && state_reg == ST_SWEEP)

endmodule
